[src/bracket_balance_checker_top_assert.svh]
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// Both macros expect signals named clock and reset in the enclosing module.
`define BBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bbc_pkg.sv]
package bbc_pkg;

   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_PAREN_OPEN   = 8'd40;
   localparam logic [7:0] CHAR_PAREN_CLOSE  = 8'd41;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'd91;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'd93;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'd123;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'd125;

   typedef enum logic {
      KIND_PUSH,
      KIND_CLOSE
   } kind_type;

   // For a closing byte, code holds the opener that it must find on the stack.
   typedef struct packed {
      logic [7:0] code;
      kind_type   kind;
      logic       last;
   } item_type;

   typedef struct packed {
      logic overflowed;
      logic balanced;
   } verdict_type;

endpackage

[src/bbc_front.sv]
module bbc_front (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             q_wr_valid,
   input  logic             q_wr_ready,
   output bbc_pkg::item_type q_wr_item
);
   import bbc_pkg::*;

   always_comb begin
      q_wr_item.last = req_tlast;
      q_wr_item.kind = KIND_CLOSE;
      unique case (req_tdata)
         CHAR_PAREN_CLOSE:  q_wr_item.code = CHAR_PAREN_OPEN;
         CHAR_SQUARE_CLOSE: q_wr_item.code = CHAR_SQUARE_OPEN;
         CHAR_CURLY_CLOSE:  q_wr_item.code = CHAR_CURLY_OPEN;
         default: begin
            q_wr_item.code = req_tdata;
            q_wr_item.kind = KIND_PUSH;
         end
      endcase
   end

   assign q_wr_valid = req_tvalid;
   assign req_tready = q_wr_ready;

endmodule

[src/bbc_queue.sv]
module bbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  bbc_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_ready,
   output bbc_pkg::item_type rd_item
);
   import bbc_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_wr, do_rd;

   assign wr_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[src/bbc_back.sv]
`include "bracket_balance_checker_top_assert.svh"

module bbc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_rd_valid,
   output logic                 q_rd_ready,
   input  bbc_pkg::item_type    q_rd_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbc_pkg::verdict_type rsp_verdict
);
   import bbc_pkg::*;

   // The top of the stack is held in top_ff and the entry below it in rd_ff.
   logic [7:0]        stack_mem [STACK_DEPTH];
   logic [7:0]        top_ff, top_in;
   logic [7:0]        rd_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              failed_ff, failed_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       rsp_data_ff, rsp_data_in;
   logic              out_free, take, wr_en;
   logic [ADDR_W-1:0] rd_addr;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign q_rd_ready = !q_rd_item.last || out_free;
   assign take       = q_rd_valid && q_rd_ready;

   always_comb begin
      count_in     = count_ff;
      top_in       = top_ff;
      failed_in    = failed_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         if (!failed_ff) begin
            unique case (q_rd_item.kind)
               KIND_CLOSE: begin
                  if (count_ff == '0 || top_ff != q_rd_item.code) begin
                     failed_in = 1'b1;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     top_in   = rd_ff;
                  end
               end
               KIND_PUSH: begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     failed_in = 1'b1;
                     ovf_in    = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     top_in   = q_rd_item.code;
                  end
               end
            endcase
         end
         if (q_rd_item.last) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.balanced   = !failed_in && (count_in == '0);
            rsp_data_in.overflowed = ovf_in;
            count_in               = '0;
            failed_in              = 1'b0;
            ovf_in                 = 1'b0;
         end
      end
   end

   assign rd_addr = ADDR_W'(count_in - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= q_rd_item.code;
      end
      rd_ff <= stack_mem[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_data_ff;

   `BBC_ASSERT_NEXT(a_full_push_overflows, take && !failed_ff && q_rd_item.kind == KIND_PUSH && count_ff == CNT_W'(STACK_DEPTH), ovf_ff || (rsp_valid_ff && rsp_data_ff.overflowed), "push onto a full stack did not flag overflow")
   `BBC_ASSERT_NEXT(a_failed_holds_stack, take && failed_ff && !q_rd_item.last, $stable(count_ff) && failed_ff, "stack changed after a failure")
   `BBC_ASSERT_NEXT(a_last_clears_state, take && q_rd_item.last, count_ff == '0 && !failed_ff && !ovf_ff && rsp_valid_ff, "final byte did not clear state and give a verdict")
   `BBC_ASSERT_NOW(a_overflow_implies_fail, ovf_ff, failed_ff, "overflow flag set without failure flag")

endmodule

[src/bracket_balance_checker_top.sv]
// Checks a byte string for balanced brackets: one byte is accepted per request and per clock
// cycle, req_tlast marks the final byte, and one verdict follows on the rsp channel once
// that byte has passed the queue and the registered verdict output. A four-entry queue parts
// the classifier from the stack engine, which handles one byte per cycle because each step
// touches only the registered stack top and the entry below it, prefetched from a 64-entry
// stack memory; the stack needs no clearing pass after reset. The engine holds a final byte
// while a verdict waits; input only stalls while a verdict waits and the queue has filled.
module bracket_balance_checker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] balanced, [1] overflowed, [7:2] zero
);
   import bbc_pkg::*;

   logic        q_wr_valid, q_wr_ready;
   item_type    q_wr_item;
   logic        q_rd_valid, q_rd_ready;
   item_type    q_rd_item;
   verdict_type rsp_verdict;

   bbc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_wr_valid (q_wr_valid),
      .q_wr_ready (q_wr_ready),
      .q_wr_item  (q_wr_item)
   );

   bbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_item  (q_wr_item),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_item  (q_rd_item)
   );

   bbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_rd_valid  (q_rd_valid),
      .q_rd_ready  (q_rd_ready),
      .q_rd_item   (q_rd_item),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_verdict (rsp_verdict)
   );

   assign rsp_tdata = {6'b0, rsp_verdict};

endmodule

[tb/bracket_verdict_checker.sv]
`timescale 1ns / 1ps

module bracket_verdict_checker
   import bbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   output int unsigned mismatch_count,
   output int unsigned verdicts_waiting
);

   logic [7:0]  shadow_stack [STACK_DEPTH];
   int unsigned shadow_fill;
   logic        shadow_failed;
   logic        shadow_overflow;
   verdict_type verdict_queue [$];

   task automatic predict_byte(input logic [7:0] code, input logic last);
      logic [7:0]  wanted;
      logic        closing;
      verdict_type verdict;
      closing = 1'b1;
      case (code)
         CHAR_PAREN_CLOSE:  wanted = CHAR_PAREN_OPEN;
         CHAR_SQUARE_CLOSE: wanted = CHAR_SQUARE_OPEN;
         CHAR_CURLY_CLOSE:  wanted = CHAR_CURLY_OPEN;
         default: begin
            wanted  = 8'd0;
            closing = 1'b0;
         end
      endcase
      if (!shadow_failed) begin
         if (closing) begin
            if (shadow_fill == 0 || shadow_stack[shadow_fill - 1] != wanted) begin
               shadow_failed = 1'b1;
            end else begin
               shadow_fill--;
            end
         end else if (shadow_fill >= STACK_DEPTH) begin
            shadow_failed   = 1'b1;
            shadow_overflow = 1'b1;
         end else begin
            shadow_stack[shadow_fill] = code;
            shadow_fill++;
         end
      end
      if (last) begin
         verdict.balanced   = !shadow_failed && shadow_fill == 0;
         verdict.overflowed = shadow_overflow;
         verdict_queue.push_back(verdict);
         shadow_fill     = 0;
         shadow_failed   = 1'b0;
         shadow_overflow = 1'b0;
      end
   endtask

   task automatic check_verdict(input logic [7:0] data);
      verdict_type seen;
      verdict_type wanted;
      seen = verdict_type'(data[1:0]);
      if (verdict_queue.size() == 0) begin
         $display("%0t: verdict expected none, actual %b", $time, data);
         mismatch_count++;
      end else begin
         wanted = verdict_queue.pop_front();
         if (seen.balanced !== wanted.balanced) begin
            $display("%0t: balanced expected %b, actual %b", $time,
                     wanted.balanced, seen.balanced);
            mismatch_count++;
         end
         if (seen.overflowed !== wanted.overflowed) begin
            $display("%0t: overflowed expected %b, actual %b", $time,
                     wanted.overflowed, seen.overflowed);
            mismatch_count++;
         end
         if (data[7:2] !== 6'd0) begin
            $display("%0t: padding expected %b, actual %b", $time, 6'd0, data[7:2]);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_fill     = 0;
         shadow_failed   = 1'b0;
         shadow_overflow = 1'b0;
         mismatch_count  = 0;
         verdict_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_verdict(rsp_tdata);
         end
      end
      verdicts_waiting = verdict_queue.size();
   end

endmodule

[tb/tb_bracket_balance_checker_top.sv]
`timescale 1ns / 1ps

module tb_bracket_balance_checker_top;
   import bbc_pkg::*;

   localparam int unsigned REQUEST_TARGET = 1650;
   localparam int unsigned CYCLE_LIMIT    = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   int unsigned mismatch_count;
   int unsigned verdicts_waiting;
   int unsigned cycle_count    = 0;
   int unsigned requests_sent  = 0;
   int unsigned burst_left     = 0;
   int unsigned stall_mode     = 0;
   int unsigned stall_phase    = 0;
   logic [7:0]  text_bytes [$];

   always #10 clock = ~clock;

   bracket_balance_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bracket_verdict_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .verdicts_waiting (verdicts_waiting)
   );

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_phase <= $urandom_range(20, 120);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] random_opener();
      case ($urandom_range(0, 2))
         0:       return CHAR_PAREN_OPEN;
         1:       return CHAR_SQUARE_OPEN;
         default: return CHAR_CURLY_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] closer_of(input logic [7:0] opener);
      case (opener)
         CHAR_PAREN_OPEN:  return CHAR_PAREN_CLOSE;
         CHAR_SQUARE_OPEN: return CHAR_SQUARE_CLOSE;
         default:          return CHAR_CURLY_CLOSE;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] code, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
   endtask

   task automatic send_string(input string s);
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) begin
         text_bytes.push_back(s[i]);
      end
      send_text();
   endtask

   task automatic compose_string();
      int unsigned style;
      int unsigned target;
      int unsigned reach;
      int unsigned spot;
      logic [7:0]  open_stack [$];
      logic [7:0]  opener;
      text_bytes.delete();
      style = $urandom_range(0, 99);
      if (style < 5) begin
         case ($urandom_range(0, 3))
            0:       reach = STACK_DEPTH - 1;
            1:       reach = STACK_DEPTH;
            2:       reach = STACK_DEPTH + 1;
            default: reach = $urandom_range(STACK_DEPTH + 2, STACK_DEPTH + 6);
         endcase
         repeat (reach) begin
            opener = random_opener();
            open_stack.push_back(opener);
            text_bytes.push_back(opener);
         end
         while (open_stack.size() != 0) begin
            text_bytes.push_back(closer_of(open_stack.pop_back()));
         end
      end else if (style < 15) begin
         repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         target = $urandom_range(1, 12) * 2;
         while (text_bytes.size() < target || open_stack.size() != 0) begin
            if (open_stack.size() == 0 ||
                (text_bytes.size() + open_stack.size() < target &&
                 $urandom_range(0, 1) == 1)) begin
               opener = random_opener();
               open_stack.push_back(opener);
               text_bytes.push_back(opener);
            end else begin
               text_bytes.push_back(closer_of(open_stack.pop_back()));
            end
         end
      end
      if ($urandom_range(0, 9) < 3) begin
         spot = $urandom_range(0, text_bytes.size() - 1);
         case ($urandom_range(0, 3))
            0: text_bytes[spot] = 8'($urandom_range(0, 255));
            1: if (text_bytes.size() > 1) opener = text_bytes.pop_back();
            2: text_bytes.push_front(closer_of(random_opener()));
            default: text_bytes[spot] = closer_of(random_opener());
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_string("([{}])");
      send_string(")");
      send_string("(]");
      send_string("{");
      send_string("]()");
      send_string("()");
      send_string("x)");
      text_bytes.delete();
      text_bytes.push_back(8'h00);
      send_text();
      text_bytes.delete();
      text_bytes.push_back(8'hFF);
      send_text();

      while (requests_sent < REQUEST_TARGET) begin
         compose_string();
         send_text();
      end

      req_tvalid <= 1'b0;
      while (verdicts_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && verdicts_waiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/bbc_pkg.sv
src/bbc_front.sv
src/bbc_queue.sv
src/bbc_back.sv
src/bracket_balance_checker_top.sv
tb/bracket_verdict_checker.sv
tb/tb_bracket_balance_checker_top.sv
